FILE: rtl/ptbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptbs_pkg
// Types, widths and codes shared by the per-port token bucket shaper.
// ----------------------------------------------------------------------------
package ptbs_pkg;

  localparam int PORTS      = 4;
  localparam int RATE_SHIFT = 16;

  localparam int PortW   = 2;
  localparam int BucketW = 30;
  localparam int TokW    = 31;
  localparam int RateW   = 32;
  localparam int TimeW   = 64;
  localparam int LenW    = 16;
  localparam int CntW    = 64;
  localparam int HalfW   = TimeW / 2;
  localparam int ProdW   = TimeW + RateW;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 32;

  localparam logic KIND_INIT = 1'b0;
  localparam logic KIND_TX   = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_SHAPING_ON = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUCKET     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RATE       = 2'd2;

  typedef enum logic [1:0] {
    ST_SENT  = 2'd0,
    ST_HELD  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_INIT  = 2'd3
  } status_e;

  typedef struct packed {
    logic            kind;
    logic [PortW-1:0] port;
    logic            present;
    logic [LenW-1:0] length;
  } ptbs_attr_t;

  typedef struct packed {
    ptbs_attr_t      attr;
    logic [TokW-1:0] growth;
  } ptbs_item_t;

  function automatic logic port_ok(input logic [PortW-1:0] p);
    return {1'b0, p} < (PortW+1)'(PORTS);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ptbs_grow.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptbs_grow
// Elapsed time per port, split rate multiply, and saturated token growth.
// ----------------------------------------------------------------------------
module ptbs_grow import ptbs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               shaping_on_i,
  input  wire logic [BucketW-1:0] bucket_size_i,
  input  wire logic [RateW-1:0]   rate_scale_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ptbs_attr_t         in_attr_i,
  input  wire logic [TimeW-1:0]   in_now_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ptbs_item_t              out_item_o
);

  logic             v0_q, v1_q, v2_q;
  ptbs_attr_t       attr0_q, attr1_q;
  logic [TimeW-1:0] now0_q;
  logic [TimeW-1:0] plo_q, phi_q;
  ptbs_item_t       item2_q;
  logic [TimeW-1:0] last_time_q [PORTS];

  logic             en0, en1, en2;
  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] plo_d, phi_d;
  logic             lt_upd;
  logic [ProdW-1:0] prod, shifted;
  logic [TokW-1:0]  cap, growth;

  assign en2 = !v2_q || out_ready_i;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_ready_o = en0;

  assign elapsed = now0_q - last_time_q[attr0_q.port];
  assign plo_d   = elapsed[HalfW-1:0] * rate_scale_i;
  assign phi_d   = elapsed[TimeW-1:HalfW] * rate_scale_i;
  assign lt_upd  = v0_q && en1 && port_ok(attr0_q.port) &&
                   (attr0_q.kind == KIND_INIT || shaping_on_i);

  assign prod    = {{RateW{1'b0}}, plo_q} + {phi_q, {HalfW{1'b0}}};
  assign shifted = prod >> RATE_SHIFT;
  assign cap     = {bucket_size_i, 1'b0};
  assign growth  = ((|shifted[ProdW-1:TokW]) || (shifted[TokW-1:0] >= cap)) ?
                   cap : shifted[TokW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int i = 0; i < PORTS; i++) begin
        last_time_q[i] <= '0;
      end
    end else begin
      if (en0) begin
        v0_q <= in_valid_i;
      end
      if (en1) begin
        v1_q <= v0_q;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (lt_upd) begin
        last_time_q[attr0_q.port] <= now0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      attr0_q <= in_attr_i;
      now0_q  <= in_now_i;
    end
    if (en1 && v0_q) begin
      attr1_q <= attr0_q;
      plo_q   <= plo_d;
      phi_q   <= phi_d;
    end
    if (en2 && v1_q) begin
      item2_q.attr   <= attr1_q;
      item2_q.growth <= growth;
    end
  end

  assign out_valid_o = v2_q;
  assign out_item_o  = item2_q;

endmodule
`default_nettype wire

FILE: rtl/ptbs_bucket.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptbs_bucket
// Per-port token level and send counters, decision and result register.
// ----------------------------------------------------------------------------
module ptbs_bucket import ptbs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               shaping_on_i,
  input  wire logic [BucketW-1:0] bucket_size_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ptbs_item_t         in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [TokW-1:0]         token_level_o,
  output logic [CntW-1:0]         packets_out_o,
  output logic [CntW-1:0]         bytes_out_o
);

  logic [TokW-1:0] tokens_q   [PORTS];
  logic [CntW-1:0] packets_q  [PORTS];
  logic [CntW-1:0] bytes_q    [PORTS];

  logic            out_valid_q;
  status_e         status_q;
  logic [TokW-1:0] level_out_q;
  logic [CntW-1:0] pkts_out_q, bytes_out_q;

  logic            take, ok;
  logic [PortW-1:0] pi;
  logic [TokW-1:0] tok, cap, level, tok_sent, tok_d;
  logic [TokW:0]   sum;
  logic            held, send;
  status_e         status_d;
  logic [CntW-1:0] pkts_d, bytes_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign pi    = in_item_i.attr.port;
  assign ok    = port_ok(pi);
  assign tok   = tokens_q[pi];
  assign cap   = {bucket_size_i, 1'b0};
  assign sum   = {1'b0, tok} + {1'b0, in_item_i.growth};
  assign level = (sum > {1'b0, cap}) ? cap : sum[TokW-1:0];
  assign held  = shaping_on_i && (level < {1'b0, bucket_size_i});
  assign tok_sent = (level > TokW'(in_item_i.attr.length)) ?
                    level - TokW'(in_item_i.attr.length) : '0;
  assign send  = (in_item_i.attr.kind == KIND_TX) && !held && in_item_i.attr.present;

  always_comb begin
    pkts_d  = packets_q[pi];
    bytes_d = bytes_q[pi];
    tok_d   = tok;
    if (in_item_i.attr.kind == KIND_INIT) begin
      status_d = ST_INIT;
      tok_d    = {1'b0, bucket_size_i};
    end else begin
      if (shaping_on_i) begin
        tok_d = level;
      end
      if (held) begin
        status_d = ST_HELD;
      end else if (!in_item_i.attr.present) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = ST_SENT;
        pkts_d   = packets_q[pi] + CntW'(1);
        bytes_d  = bytes_q[pi] + CntW'(in_item_i.attr.length);
        if (shaping_on_i) begin
          tok_d = tok_sent;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < PORTS; i++) begin
        tokens_q[i]  <= '0;
        packets_q[i] <= '0;
        bytes_q[i]   <= '0;
      end
    end else begin
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
      if (take && ok) begin
        tokens_q[pi] <= tok_d;
        if (send) begin
          packets_q[pi] <= pkts_d;
          bytes_q[pi]   <= bytes_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (ok) begin
        status_q    <= status_d;
        level_out_q <= tok_d;
        pkts_out_q  <= pkts_d;
        bytes_out_q <= bytes_d;
      end else begin
        status_q    <= ST_EMPTY;
        level_out_q <= '0;
        pkts_out_q  <= '0;
        bytes_out_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign token_level_o = level_out_q;
  assign packets_out_o = pkts_out_q;
  assign bytes_out_o   = bytes_out_q;

endmodule
`default_nettype wire

FILE: rtl/per_port_token_bucket_shaper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_port_token_bucket_shaper
// Per-port token bucket transmit shaper with packet and byte counters.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o): kind, port, time stamp, packet
//   flag and length. Kind INIT loads the port's bucket and time; kind TX is a
//   transmit attempt. Result channel (out_valid_o/out_ready_i): status, token
//   level and the port's packet and byte totals, one result per request.
//   Config port (cfg_we_i, cfg_index_i, cfg_data_i): shaping enable, bucket
//   size, rate scale; write only while no request is in flight.
// Timing:
//   One request per cycle sustained while results are taken. Stages from
//   acceptance to out_valid_o: time register, split 32x32 rate multiply,
//   product combine/saturate, then the token update that closes the
//   per-port loop into the result register.
// Reset:
//   All buckets, times and counters clear to zero; config clears to zero.
// Stall:
//   A held result keeps its value; requests keep entering until every
//   pipeline stage is full, then in_ready_o drops.
// ----------------------------------------------------------------------------
module per_port_token_bucket_shaper import ptbs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic [PortW-1:0]   port_i,
  input  wire logic [TimeW-1:0]   now_i,
  input  wire logic               packet_present_i,
  input  wire logic [LenW-1:0]    packet_length_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [TokW-1:0]         token_level_o,
  output logic [CntW-1:0]         packets_out_o,
  output logic [CntW-1:0]         bytes_out_o
);

  logic               shaping_q;
  logic [BucketW-1:0] bucket_q;
  logic [RateW-1:0]   rate_q;

  ptbs_attr_t attr;
  ptbs_item_t item;
  logic       item_valid, item_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shaping_q <= 1'b0;
      bucket_q  <= '0;
      rate_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SHAPING_ON: shaping_q <= cfg_data_i[0];
        CFG_BUCKET:     bucket_q  <= cfg_data_i[BucketW-1:0];
        CFG_RATE:       rate_q    <= cfg_data_i[RateW-1:0];
        default:        ;
      endcase
    end
  end

  assign attr.kind    = kind_i;
  assign attr.port    = port_i;
  assign attr.present = packet_present_i;
  assign attr.length  = packet_length_i;

  ptbs_grow u_grow (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .shaping_on_i  (shaping_q),
    .bucket_size_i (bucket_q),
    .rate_scale_i  (rate_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_attr_i     (attr),
    .in_now_i      (now_i),
    .out_valid_o   (item_valid),
    .out_ready_i   (item_ready),
    .out_item_o    (item)
  );

  ptbs_bucket u_bucket (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .shaping_on_i  (shaping_q),
    .bucket_size_i (bucket_q),
    .in_valid_i    (item_valid),
    .in_ready_o    (item_ready),
    .in_item_i     (item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .token_level_o (token_level_o),
    .packets_out_o (packets_out_o),
    .bytes_out_o   (bytes_out_o)
  );

endmodule
`default_nettype wire

FILE: rtl/ptbs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptbs_checker
// Port-level checks for the per-port token bucket shaper.
// ----------------------------------------------------------------------------
module ptbs_checker import ptbs_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [1:0]         status_o,
  input wire logic [TokW-1:0]    token_level_o,
  input wire logic [CntW-1:0]    packets_out_o
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(token_level_o))
    else $error("result changed while stalled");

  // backpressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request side stalled without a stalled result");

  // level is capped at twice a 30-bit bucket
  a_level_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_level_o != {TokW{1'b1}})
    else $error("token level above cap");

  // a sent packet always shows a nonzero packet total
  a_sent_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SENT |-> packets_out_o != '0)
    else $error("sent with zero packet count");

endmodule

bind per_port_token_bucket_shaper ptbs_checker u_ptbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .token_level_o (token_level_o),
  .packets_out_o (packets_out_o)
);
`default_nettype wire
